[sv/assert_macros.svh]
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion violated: condition must never hold");

// trigger in one cycle implies the condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion violated: expected follow-up did not occur");

`endif

[sv/b64_pkg.sv]
// types, character constants and sextet lookup for the base64 encoder
`default_nettype none

package b64_pkg;

  // one closed group of up to three bytes, missing bytes zero
  typedef struct packed {
    logic [23:0] bytes;   // first byte in the top bits
    logic [1:0]  nbytes;  // 1 to 3 real bytes
    logic        fin;     // group ends the message
  } grp_t;

  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_DIGIT_0 = 7'h30;
  localparam logic [6:0] CH_PLUS    = 7'h2B;
  localparam logic [6:0] CH_SLASH   = 7'h2F;
  localparam logic [6:0] CH_PAD     = 7'h3D;

  localparam logic [1:0] LAST_IDX   = 2'd3;
  localparam logic [1:0] FULL_COUNT = 2'd2;

  // sextet to character of the standard alphabet
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    case (v) inside
      [6'd0:6'd25]:  sym = CH_UPPER_A + v7;
      [6'd26:6'd51]: sym = CH_LOWER_A + v7 - 7'd26;
      [6'd52:6'd61]: sym = CH_DIGIT_0 + v7 - 7'd52;
      6'd62:         sym = CH_PLUS;
      default:       sym = CH_SLASH;
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/b64_front.sv]
// front end: collects bytes into groups of up to three and closes them
`default_nettype none

module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic              q_full,
  output logic              push,
  output b64_pkg::grp_t     push_grp
);
  import b64_pkg::*;

  logic [1:0] cnt;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       accept;
  logic       closes;

  // hold input while the queue has no room
  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign closes     = (cnt == FULL_COUNT) || final_byte;
  assign push       = accept && closes;

  // assemble the closing group, missing bytes zero
  always_comb begin
    push_grp.bytes[23:16] = (cnt == 2'd0) ? data_byte : pend0;
    push_grp.bytes[15:8]  = (cnt == 2'd1) ? data_byte :
                            ((cnt == FULL_COUNT) ? pend1 : 8'd0);
    push_grp.bytes[7:0]   = (cnt == FULL_COUNT) ? data_byte : 8'd0;
    push_grp.nbytes       = cnt + 2'd1;
    push_grp.fin          = final_byte;
  end

  // pending byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= closes ? 2'd0 : cnt + 2'd1;
    end
  end

  // pending byte storage
  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      if (cnt == 2'd0) begin
        pend0 <= data_byte;
      end else begin
        pend1 <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

[sv/b64_queue.sv]
// short register queue of closed groups between front and back
`default_nettype none
`include "assert_macros.svh"

module b64_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::grp_t push_grp,
  output logic          full,
  output logic          q_valid,
  input  logic          pop,
  output b64_pkg::grp_t pop_grp
);
  import b64_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign pop_grp = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_grp;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !q_valid)

endmodule

`default_nettype wire

[sv/b64_back.sv]
// back end: turns each group into four characters, one per beat
`default_nettype none
`include "assert_macros.svh"

module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  b64_pkg::grp_t q_grp,
  output logic          pop,
  output logic          char_valid,
  input  logic          char_stall,
  output logic [6:0]    out_char,
  output logic          out_last
);
  import b64_pkg::*;

  grp_t       grp;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic [5:0] sextet;
  logic [6:0] ch;
  logic       last;

  // output register free and a group in work
  assign advance = busy && (!char_valid || !char_stall);
  // take the next group when idle or on the last character
  assign pop     = q_valid && (!busy || (advance && idx == LAST_IDX));

  // select sextet and map to a character or pad
  always_comb begin
    case (idx)
      2'd0:    sextet = grp.bytes[23:18];
      2'd1:    sextet = grp.bytes[17:12];
      2'd2:    sextet = grp.bytes[11:6];
      default: sextet = grp.bytes[5:0];
    endcase
    ch   = (idx > grp.nbytes) ? CH_PAD : sym(sextet);
    last = grp.fin && (idx == LAST_IDX);
  end

  // sequencing and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (advance) begin
        char_valid <= 1'b1;
      end else if (char_valid && !char_stall) begin
        char_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (advance) begin
        idx <= idx + 2'd1;
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // group and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= q_grp;
    end
    if (advance) begin
      out_char <= ch;
      out_last <= last;
    end
  end

  `ASSERT_NEXT(a_pop_starts, clk, rst, pop, busy && idx == 2'd0)
  `ASSERT_NEVER(a_pop_midgroup, clk, rst, pop && busy && idx != LAST_IDX)

endmodule

`default_nettype wire

[sv/base64_stream_encoder_top.sv]
// base64 stream encoder: bytes in, padded base64 characters out
// a closed group passes a queue entry and the back end's group register, and its
// characters leave the output register; throughput: the back end emits one character
//   per cycle while not stalled and a group is queued, four characters per group
// the group queue (QUEUE_DEPTH entries) stalls input only when it is full
// synchronous active-high reset clears pending count, queue and output valid
`default_nettype none

module base64_stream_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] out_char,
  output logic       out_last
);
  import b64_pkg::*;

  grp_t push_grp;
  grp_t pop_grp;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  // byte collection
  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_grp   (push_grp)
  );

  // group queue
  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_grp  (pop_grp)
  );

  // character generation
  b64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_grp      (pop_grp),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
